[rtl/mlhp_pkg.sv]
// ---------------------------------------------------------------------------
// mlhp_pkg
// shared types and constants of the lace header parser
// ---------------------------------------------------------------------------
`default_nettype none
package mlhp_pkg;
    localparam int unsigned SizeW = 24;
    localparam int unsigned TimeW = 63;
    localparam int unsigned CntW  = 7;
    localparam int unsigned IdxW  = 6;

    localparam logic [1:0] MODE_NONE  = 2'd0;
    localparam logic [1:0] MODE_XIPH  = 2'd1;
    localparam logic [1:0] MODE_FIXED = 2'd2;
    localparam logic [1:0] MODE_EBML  = 2'd3;

    localparam logic [1:0] ERR_NONE  = 2'd0;
    localparam logic [1:0] ERR_COUNT = 2'd1;
    localparam logic [1:0] ERR_SIZE  = 2'd2;

    localparam logic [7:0] XIPH_RUN = 8'hff;

    // one parsed block handed to the emitter
    typedef struct packed {
        logic [1:0]       err;
        logic [1:0]       mode;
        logic [CntW-1:0]  n;
        logic [SizeW-1:0] rem;
        logic [SizeW-1:0] sum;
        logic [TimeW-1:0] base;
        logic [TimeW-1:0] next;
        logic             has_next;
        logic             valid;
        logic             upd;
    } t_job;

    // lace size store write
    typedef struct packed {
        logic             en;
        logic [IdxW-1:0]  addr;
        logic [SizeW-1:0] data;
    } t_mwr;
endpackage
`default_nettype wire

[rtl/mlhp_div.sv]
// ---------------------------------------------------------------------------
// mlhp_div
// restoring divider, one quotient bit per cycle, small divisor
// ---------------------------------------------------------------------------
`default_nettype none
module mlhp_div
    import mlhp_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_start,
    input  wire logic [TimeW-1:0] i_dividend,
    input  wire logic [CntW-1:0]  i_divisor,
    output logic                  o_done,
    output logic [TimeW-1:0]      o_quot
);
    logic             r_busy;
    logic             r_done;
    logic [5:0]       r_cnt;
    logic [CntW-1:0]  r_rem;
    logic [TimeW-1:0] r_q;
    logic [CntW:0]    w_trial;
    logic             w_ge;

    assign w_trial = {r_rem, r_q[TimeW-1]};
    assign w_ge    = w_trial >= {1'b0, i_divisor};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 6'd1;
                if (r_cnt == 6'(TimeW - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_q   <= i_dividend;
        end else if (r_busy) begin
            r_rem <= w_ge ? CntW'(w_trial - {1'b0, i_divisor}) : w_trial[CntW-1:0];
            r_q   <= {r_q[TimeW-2:0], w_ge};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;
endmodule
`default_nettype wire

[rtl/mlhp_front.sv]
// ---------------------------------------------------------------------------
// mlhp_front
// header byte parser: lacing mode, lace count and coded lace sizes
// ---------------------------------------------------------------------------
`default_nettype none
module mlhp_front
    import mlhp_pkg::*;
#(
    parameter int unsigned MAX_LACES = 64
)
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_accept,
    input  wire logic             i_command,
    input  wire logic [7:0]       i_byte_value,
    input  wire logic [SizeW-1:0] i_block_size,
    input  wire logic [TimeW-1:0] i_block_time,
    input  wire logic [TimeW-1:0] i_next_time,
    input  wire logic             i_has_next,
    input  wire logic             i_is_first_block,
    output logic                  o_push,
    output t_job                  o_job,
    output t_mwr                  o_wr
);
    localparam logic [2:0] PH_IDLE  = 3'd0;
    localparam logic [2:0] PH_TC0   = 3'd1;
    localparam logic [2:0] PH_TC1   = 3'd2;
    localparam logic [2:0] PH_FLAGS = 3'd3;
    localparam logic [2:0] PH_COUNT = 3'd4;
    localparam logic [2:0] PH_XIPH  = 3'd5;
    localparam logic [2:0] PH_VHEAD = 3'd6;
    localparam logic [2:0] PH_VREST = 3'd7;

    logic [2:0]       r_phase,  n_phase;
    logic [1:0]       r_mode,   n_mode;
    logic [CntW-1:0]  r_count,  n_count;
    logic [IdxW-1:0]  r_cur,    n_cur;
    logic [SizeW-1:0] r_acc,    n_acc;
    logic [55:0]      r_vint,   n_vint;
    logic [3:0]       r_vleft,  n_vleft;
    logic [3:0]       r_vlen,   n_vlen;
    logic [SizeW-1:0] r_rem,    n_rem;
    logic [SizeW-1:0] r_sum,    n_sum;
    logic [TimeW-1:0] r_base,   n_base;
    logic [TimeW-1:0] r_next,   n_next;
    logic             r_hasn,   n_hasn;
    logic             r_tvalid, n_tvalid;

    always_comb begin
        logic [1:0]       err;
        logic             cmpl;
        logic             vdone;
        logic [55:0]      vv;
        logic [3:0]       vlen;
        logic [5:0]       sh;
        logic [55:0]      bias;
        logic [57:0]      cur;
        logic [SizeW-1:0] avail;
        logic [SizeW-1:0] xacc;
        logic [8:0]       b1;
        logic [3:0]       lz;

        n_phase = r_phase;  n_mode = r_mode;   n_count = r_count; n_cur = r_cur;
        n_acc = r_acc;      n_vint = r_vint;   n_vleft = r_vleft; n_vlen = r_vlen;
        n_rem = r_rem;      n_sum = r_sum;     n_base = r_base;   n_next = r_next;
        n_hasn = r_hasn;    n_tvalid = r_tvalid;
        err = ERR_NONE; cmpl = 1'b0; vdone = 1'b0; vv = r_vint; vlen = r_vlen;
        sh = '0; bias = '0; cur = '0; avail = '0; xacc = '0;
        b1 = {1'b0, i_byte_value} + 9'd1;
        lz = 4'd1;
        o_push = 1'b0;
        o_job  = '0;
        o_wr   = '0;

        if (i_accept && !i_command) begin
            n_rem    = (i_block_size >= SizeW'(3)) ? i_block_size - SizeW'(3) : '0;
            n_base   = i_block_time;
            n_next   = i_next_time;
            n_hasn   = i_has_next;
            n_tvalid = i_is_first_block || (i_block_time != '0);
            n_cur = '0; n_acc = '0; n_sum = '0;
            n_phase = PH_TC0;
        end else if (i_accept) begin
            unique case (r_phase)
                PH_IDLE:  n_phase = PH_IDLE;
                PH_TC0:   n_phase = PH_TC1;
                PH_TC1:   n_phase = PH_FLAGS;
                PH_FLAGS: begin
                    n_mode = i_byte_value[2:1];
                    if (i_byte_value[2:1] == MODE_NONE) begin
                        n_phase = PH_IDLE;
                        o_push = 1'b1;
                        o_job.mode = MODE_NONE;
                        o_job.n = CntW'(1);
                        o_job.rem = r_rem;
                        o_job.base = r_base;
                        o_job.valid = r_tvalid;
                    end else begin
                        n_phase = PH_COUNT;
                    end
                end
                PH_COUNT: begin
                    if (b1 > 9'(MAX_LACES)) begin
                        err = ERR_COUNT;
                    end else if (r_rem == '0) begin
                        err = ERR_SIZE;
                    end else begin
                        n_rem = r_rem - SizeW'(1);
                        n_count = b1[CntW-1:0];
                        n_cur = '0; n_acc = '0; n_sum = '0;
                        if (r_mode == MODE_FIXED || b1 == 9'd1) cmpl = 1'b1;
                        else n_phase = (r_mode == MODE_XIPH) ? PH_XIPH : PH_VHEAD;
                    end
                end
                PH_XIPH: begin
                    if ({1'b0, r_rem} < {{(SizeW-8){1'b0}}, b1}) begin
                        err = ERR_SIZE;
                    end else begin
                        n_rem = r_rem - SizeW'(b1);
                        xacc = r_acc + SizeW'(i_byte_value);
                        n_acc = xacc;
                        if (i_byte_value != XIPH_RUN) begin
                            o_wr.en = 1'b1;
                            o_wr.addr = r_cur;
                            o_wr.data = xacc;
                            n_sum = r_sum + xacc;
                            n_acc = '0;
                            n_cur = r_cur + IdxW'(1);
                            if ({1'b0, r_cur} + CntW'(2) >= r_count) cmpl = 1'b1;
                        end
                    end
                end
                PH_VHEAD: begin
                    if (r_rem == '0 || i_byte_value == 8'd0) begin
                        err = ERR_SIZE;
                    end else begin
                        n_rem = r_rem - SizeW'(1);
                        for (int k = 6; k >= 0; k--) begin
                            if ((i_byte_value >> (k + 1)) == 8'd0) lz = 4'(8 - k);
                        end
                        vlen = lz;
                        vv = {48'd0, i_byte_value & 8'(8'hff >> lz)};
                        n_vint = vv;
                        n_vlen = lz;
                        n_vleft = lz - 4'd1;
                        if (lz == 4'd1) vdone = 1'b1;
                        else n_phase = PH_VREST;
                    end
                end
                PH_VREST: begin
                    if (r_rem == '0) begin
                        err = ERR_SIZE;
                    end else begin
                        n_rem = r_rem - SizeW'(1);
                        vv = {r_vint[47:0], i_byte_value};
                        n_vint = vv;
                        n_vleft = r_vleft - 4'd1;
                        if (r_vleft == 4'd1) vdone = 1'b1;
                    end
                end
            endcase
        end

        if (vdone) begin
            if (r_cur == '0) begin
                cur = {2'b00, vv};
                if (vv[55:24] != '0) err = ERR_SIZE;
            end else begin
                sh = 6'({2'b00, vlen} * 6'd7) - 6'd1;
                bias = (56'd1 << sh) - 56'd1;
                cur = {34'd0, r_acc} + {2'b00, vv} - {2'b00, bias};
                if (cur[57] || cur == '0) err = ERR_SIZE;
            end
            avail = n_rem - r_sum;
            if (n_rem < r_sum || cur > {34'd0, avail}) err = ERR_SIZE;
            if (err == ERR_NONE) begin
                o_wr.en = 1'b1;
                o_wr.addr = r_cur;
                o_wr.data = cur[SizeW-1:0];
                n_acc = cur[SizeW-1:0];
                n_sum = r_sum + cur[SizeW-1:0];
                n_cur = r_cur + IdxW'(1);
                if ({1'b0, r_cur} + CntW'(2) >= r_count) cmpl = 1'b1;
                else n_phase = PH_VHEAD;
            end
        end

        if (err != ERR_NONE) begin
            n_phase = PH_IDLE;
            o_push = 1'b1;
            o_wr = '0;
            o_job = '0;
            o_job.err = err;
        end else if (cmpl) begin
            n_phase = PH_IDLE;
            n_cur = '0;
            o_push = 1'b1;
            o_job.err = (r_mode == MODE_EBML && n_rem < n_sum) ? ERR_SIZE : ERR_NONE;
            o_job.mode = r_mode;
            o_job.n = n_count;
            o_job.rem = n_rem;
            o_job.sum = n_sum;
            o_job.base = r_base;
            o_job.next = r_next;
            o_job.has_next = r_hasn;
            o_job.valid = r_tvalid;
            o_job.upd = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE; r_mode <= '0; r_count <= '0; r_cur <= '0;
            r_acc <= '0; r_vint <= '0; r_vleft <= '0; r_vlen <= '0;
            r_rem <= '0; r_sum <= '0; r_base <= '0; r_next <= '0;
            r_hasn <= 1'b0; r_tvalid <= 1'b0;
        end else begin
            r_phase <= n_phase; r_mode <= n_mode; r_count <= n_count; r_cur <= n_cur;
            r_acc <= n_acc; r_vint <= n_vint; r_vleft <= n_vleft; r_vlen <= n_vlen;
            r_rem <= n_rem; r_sum <= n_sum; r_base <= n_base; r_next <= n_next;
            r_hasn <= n_hasn; r_tvalid <= n_tvalid;
        end
    end
endmodule
`default_nettype wire

[rtl/mlhp_back.sv]
// ---------------------------------------------------------------------------
// mlhp_back
// descriptor emitter: fixed lace size and time step division, lace size store, output register
// ---------------------------------------------------------------------------
`default_nettype none
module mlhp_back
    import mlhp_pkg::*;
#(
    parameter int unsigned MAX_LACES = 64
)
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_job_valid,
    input  t_job                  i_job,
    output logic                  o_job_pop,
    input  t_mwr                  i_wr,
    output logic                  o_idle,
    output logic                  o_out_valid,
    input  wire logic             i_out_stall,
    output logic [SizeW-1:0]      o_lace_size,
    output logic [TimeW-1:0]      o_lace_time,
    output logic                  o_time_valid,
    output logic [IdxW-1:0]       o_lace_number,
    output logic                  o_last_lace,
    output logic [1:0]            o_error_code
);
    localparam int unsigned AW = (MAX_LACES > 1) ? $clog2(MAX_LACES) : 1;

    localparam logic [2:0] B_IDLE    = 3'd0;
    localparam logic [2:0] B_DIVE_GO = 3'd1;
    localparam logic [2:0] B_DIVE    = 3'd2;
    localparam logic [2:0] B_DIVS_GO = 3'd3;
    localparam logic [2:0] B_DIVS    = 3'd4;
    localparam logic [2:0] B_RD      = 3'd5;
    localparam logic [2:0] B_EMIT    = 3'd6;
    localparam logic [2:0] B_ERR     = 3'd7;

    logic [SizeW-1:0] r_mem [MAX_LACES];
    logic [2:0]       r_state;
    t_job             r_job;
    logic [SizeW-1:0] r_each;
    logic [TimeW-1:0] r_step;
    logic [TimeW-1:0] r_t;
    logic [IdxW-1:0]  r_i;
    logic [SizeW-1:0] r_rd;
    logic             r_o_valid;
    logic [SizeW-1:0] r_o_size;
    logic [TimeW-1:0] r_o_time;
    logic             r_o_tv;
    logic [IdxW-1:0]  r_o_num;
    logic             r_o_last;
    logic [1:0]       r_o_err;

    logic             w_free;
    logic             w_load;
    logic             w_last;
    logic             w_do_step;
    logic             w_start;
    logic [TimeW-1:0] w_diff;
    logic [TimeW-1:0] w_dividend;
    logic             w_div_done;
    logic [TimeW-1:0] w_quot;
    logic [SizeW-1:0] w_size;

    assign w_free     = !r_o_valid || !i_out_stall;
    assign w_load     = ((r_state == B_EMIT) || (r_state == B_ERR)) && w_free;
    assign w_last     = ({1'b0, r_i} == r_job.n - CntW'(1));
    assign w_do_step  = r_job.upd && r_job.valid && r_job.has_next;
    assign w_start    = (r_state == B_DIVE_GO) || (r_state == B_DIVS_GO);
    assign w_diff     = (r_job.next >= r_job.base) ? r_job.next - r_job.base : '0;
    assign w_dividend = (r_state == B_DIVE_GO) ? TimeW'(r_job.rem) : w_diff;
    assign o_job_pop  = (r_state == B_IDLE) && i_job_valid;
    assign o_idle     = (r_state == B_IDLE);

    always_comb begin
        if (w_last) begin
            if (r_job.mode == MODE_EBML) w_size = r_job.rem - r_job.sum;
            else if (r_job.mode == MODE_FIXED) w_size = r_each;
            else w_size = r_job.rem;
        end else if (r_job.mode == MODE_FIXED) begin
            w_size = r_each;
        end else begin
            w_size = r_rd;
        end
    end

    mlhp_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_start),
        .i_dividend (w_dividend),
        .i_divisor  (r_job.n),
        .o_done     (w_div_done),
        .o_quot     (w_quot)
    );

    always_ff @(posedge i_clk) begin
        if (i_wr.en) r_mem[i_wr.addr[AW-1:0]] <= i_wr.data;
        if (r_state == B_RD) r_rd <= r_mem[r_i[AW-1:0]];
    end

    // output beat valid: set on a load, cleared once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (w_load) begin
            r_o_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= B_IDLE;
            r_step    <= '0;
        end else begin
            unique case (r_state)
                B_IDLE: begin
                    if (i_job_valid) begin
                        r_job <= i_job;
                        r_i   <= '0;
                        r_t   <= i_job.base;
                        if (i_job.err != ERR_NONE) r_state <= B_ERR;
                        else if (i_job.mode == MODE_FIXED) r_state <= B_DIVE_GO;
                        else if (i_job.upd && i_job.valid && i_job.has_next)
                            r_state <= B_DIVS_GO;
                        else r_state <= B_RD;
                    end
                end
                B_DIVE_GO: r_state <= B_DIVE;
                B_DIVE: begin
                    if (w_div_done) begin
                        r_each  <= w_quot[SizeW-1:0];
                        r_state <= w_do_step ? B_DIVS_GO : B_RD;
                    end
                end
                B_DIVS_GO: r_state <= B_DIVS;
                B_DIVS: begin
                    if (w_div_done) begin
                        r_step  <= w_quot;
                        r_state <= B_RD;
                    end
                end
                B_RD: r_state <= B_EMIT;
                B_EMIT: begin
                    if (w_free) begin
                        r_o_size  <= w_size;
                        r_o_time  <= r_job.valid ? r_t : '0;
                        r_o_tv    <= r_job.valid;
                        r_o_num   <= r_i;
                        r_o_last  <= w_last;
                        r_o_err   <= ERR_NONE;
                        r_i       <= r_i + IdxW'(1);
                        r_t       <= r_t + r_step;
                        r_state   <= w_last ? B_IDLE : B_RD;
                    end
                end
                B_ERR: begin
                    if (w_free) begin
                        r_o_size  <= '0;
                        r_o_time  <= '0;
                        r_o_tv    <= 1'b0;
                        r_o_num   <= '0;
                        r_o_last  <= 1'b1;
                        r_o_err   <= r_job.err;
                        r_state   <= B_IDLE;
                    end
                end
            endcase
        end
    end

    assign o_out_valid   = r_o_valid;
    assign o_lace_size   = r_o_size;
    assign o_lace_time   = r_o_time;
    assign o_time_valid  = r_o_tv;
    assign o_lace_number = r_o_num;
    assign o_last_lace   = r_o_last;
    assign o_error_code  = r_o_err;

    a_err_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_valid && r_o_err != ERR_NONE) |-> (r_o_last && r_o_num == '0 && !r_o_tv))
        else $error("error beat is not a single final descriptor");
    a_div_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_start |=> (r_state == B_DIVE || r_state == B_DIVS))
        else $error("divider started outside a divide step");
    a_no_pop_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != B_IDLE) |-> !o_job_pop)
        else $error("job taken while emitter busy");
endmodule
`default_nettype wire

[rtl/matroska_lace_header_parser_top.sv]
// ---------------------------------------------------------------------------
// matroska_lace_header_parser_top
// block lace header parser producing one descriptor per lace
// ---------------------------------------------------------------------------
// input channel: a beat with i_command low opens a block (size, times, flags),
// beats with i_command high carry header bytes, one byte a beat
// output channel: one descriptor beat per lace, or a single error beat
// header bytes are taken one per cycle while the emitter is free; the front
// parser classifies them and writes lace sizes into the emitter's size store
// when a header completes, a job goes through a two-entry queue to the emitter
// with no divide, the closing header byte leads through the queue, the emitter's
// size store read and its output register load to the first descriptor; each
// divide (fixed lace size, time step) adds start, the quotient bits one by one and
// done, then each descriptor takes a size store read and an output register load
// o_in_stall stays high from header completion until the last descriptor has
// been loaded into the output register, so blocks are handled one at a time
// a stalled output holds its beat; the emitter waits on i_out_stall
// reset (synchronous, active low) clears the parser to idle, empties the
// queue, drops any pending output beat and clears the held time step
// stray header bytes while idle are swallowed without a result
// ---------------------------------------------------------------------------
`default_nettype none
module matroska_lace_header_parser_top
    import mlhp_pkg::*;
#(
    parameter int unsigned MAX_LACES = 64
)
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    output logic                  o_in_stall,
    input  wire logic             i_command,
    input  wire logic [7:0]       i_byte_value,
    input  wire logic [SizeW-1:0] i_block_size,
    input  wire logic [TimeW-1:0] i_block_time,
    input  wire logic [TimeW-1:0] i_next_time,
    input  wire logic             i_has_next,
    input  wire logic             i_is_first_block,
    output logic                  o_out_valid,
    input  wire logic             i_out_stall,
    output logic [SizeW-1:0]      o_lace_size,
    output logic [TimeW-1:0]      o_lace_time,
    output logic                  o_time_valid,
    output logic [IdxW-1:0]       o_lace_number,
    output logic                  o_last_lace,
    output logic [1:0]            o_error_code
);
    // job queue between parser and emitter
    t_job       r_q [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;

    logic       w_accept;
    logic       w_push;
    logic       w_pop;
    logic       w_back_idle;
    t_job       w_job;
    t_mwr       w_wr;

    // the size store is shared, so the parser waits for the emitter
    assign o_in_stall = !((r_cnt == 2'd0) && w_back_idle);
    assign w_accept   = i_in_valid && !o_in_stall;

    mlhp_front #(.MAX_LACES(MAX_LACES)) u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_accept         (w_accept),
        .i_command        (i_command),
        .i_byte_value     (i_byte_value),
        .i_block_size     (i_block_size),
        .i_block_time     (i_block_time),
        .i_next_time      (i_next_time),
        .i_has_next       (i_has_next),
        .i_is_first_block (i_is_first_block),
        .o_push           (w_push),
        .o_job            (w_job),
        .o_wr             (w_wr)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) r_wp <= ~r_wp;
            if (w_pop) r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(w_push) - 2'(w_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) r_q[r_wp] <= w_job;
    end

    mlhp_back #(.MAX_LACES(MAX_LACES)) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_job_valid   (r_cnt != 2'd0),
        .i_job         (r_q[r_rp]),
        .o_job_pop     (w_pop),
        .i_wr          (w_wr),
        .o_idle        (w_back_idle),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_lace_size   (o_lace_size),
        .o_lace_time   (o_lace_time),
        .o_time_valid  (o_time_valid),
        .o_lace_number (o_lace_number),
        .o_last_lace   (o_last_lace),
        .o_error_code  (o_error_code)
    );

    a_q_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= 2'd2)
        else $error("job queue overflow");
    a_stall_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_back_idle |-> o_in_stall)
        else $error("input taken while emitter busy");
    a_push_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> w_accept)
        else $error("job pushed without an input beat");
endmodule
`default_nettype wire

[tb/sv/lace_descriptor_checker.sv]
// ---------------------------------------------------------------------------
// lace_descriptor_checker
// watches both channels of the lace header parser, predicts every descriptor
// beat from the accepted input beats and compares them field by field
// ---------------------------------------------------------------------------
module lace_descriptor_checker
    import mlhp_pkg::*;
#(
    parameter int unsigned MAX_LACES = 64
)
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic             i_in_stall,
    input  logic             i_command,
    input  logic [7:0]       i_byte_value,
    input  logic [SizeW-1:0] i_block_size,
    input  logic [TimeW-1:0] i_block_time,
    input  logic [TimeW-1:0] i_next_time,
    input  logic             i_has_next,
    input  logic             i_is_first_block,
    input  logic             i_out_valid,
    input  logic             i_out_stall,
    input  logic [SizeW-1:0] i_lace_size,
    input  logic [TimeW-1:0] i_lace_time,
    input  logic             i_time_valid,
    input  logic [IdxW-1:0]  i_lace_number,
    input  logic             i_last_lace,
    input  logic [1:0]       i_error_code,
    output int               o_fail_count,
    output int               o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef enum logic [3:0] {
        HDR_IDLE, HDR_TC0, HDR_TC1, HDR_FLAGS, HDR_COUNT, HDR_XIPH, HDR_VHEAD, HDR_VREST
    } hdr_phase_t;

    typedef struct packed {
        logic [SizeW-1:0] size;
        logic [TimeW-1:0] ltime;
        logic             tv;
        logic [IdxW-1:0]  num;
        logic             last;
        logic [1:0]       err;
    } lace_desc_t;

    lace_desc_t  exp_laces[$];

    hdr_phase_t  phase;
    logic [1:0]  mode;
    int unsigned count, cursor, run_acc, vleft, vlen, rem, sum_sizes;
    logic [55:0] vval;
    int unsigned sizes[64];
    logic [63:0] step, base, nxt;
    logic        hold_next, hold_valid;

    task automatic push_error(input logic [1:0] code);
        lace_desc_t d;
        d = '0;
        d.last = 1'b1;
        d.err = code;
        phase = HDR_IDLE;
        exp_laces.push_back(d);
    endtask

    task automatic emit_laces();
        lace_desc_t  d;
        int unsigned last_sz, each;
        logic [63:0] diff, t;
        each = 0;
        if (count == 0 || count > MAX_LACES) begin
            push_error(ERR_COUNT);
            return;
        end
        if (mode == MODE_EBML) begin
            if (rem < sum_sizes) begin
                push_error(ERR_SIZE);
                return;
            end
            last_sz = rem - sum_sizes;
        end else if (mode == MODE_FIXED) begin
            each = rem / count;
            last_sz = each;
        end else begin
            last_sz = rem;
        end
        if (hold_valid && hold_next) begin
            diff = (nxt >= base) ? nxt - base : 64'd0;
            step = diff / 64'(count);
        end
        for (int unsigned i = 0; i < count; i++) begin
            t = hold_valid ? base + step * 64'(i) : 64'd0;
            d.size = (i == count - 1) ? last_sz[SizeW-1:0] :
                     (mode == MODE_FIXED) ? each[SizeW-1:0] : sizes[i % 64][SizeW-1:0];
            d.ltime = t[TimeW-1:0];
            d.tv = hold_valid;
            d.num = i[IdxW-1:0];
            d.last = (i == count - 1);
            d.err = ERR_NONE;
            exp_laces.push_back(d);
        end
        cursor = 0;
        phase = HDR_IDLE;
    endtask

    // a complete ebml vint: first one is absolute, the rest signed deltas
    task automatic close_vint();
        longint      cur, bias;
        int unsigned avail;
        if (cursor == 0) begin
            if (vval > 56'hFFFFFF) begin
                push_error(ERR_SIZE);
                return;
            end
            cur = longint'(vval);
        end else begin
            bias = (longint'(1) << (7 * vlen - 1)) - 1;
            cur = longint'(run_acc) + (longint'(vval) - bias);
            if (cur <= 0) begin
                push_error(ERR_SIZE);
                return;
            end
        end
        if (rem < sum_sizes) begin
            push_error(ERR_SIZE);
            return;
        end
        avail = rem - sum_sizes;
        if (cur > longint'(avail)) begin
            push_error(ERR_SIZE);
            return;
        end
        sizes[cursor % 64] = int'(cur);
        run_acc = int'(cur);
        sum_sizes += int'(cur);
        cursor++;
        if (cursor + 1 >= count) emit_laces();
        else phase = HDR_VHEAD;
    endtask

    task automatic take_beat();
        int unsigned b, len;
        logic [7:0]  mask;
        b = i_byte_value;
        if (!i_command) begin
            rem = (i_block_size >= 3) ? i_block_size - 3 : 0;
            base = 64'(i_block_time);
            nxt = 64'(i_next_time);
            hold_next = i_has_next;
            hold_valid = i_is_first_block || (i_block_time != '0);
            cursor = 0; run_acc = 0; sum_sizes = 0;
            phase = HDR_TC0;
            return;
        end
        case (phase)
            HDR_TC0: phase = HDR_TC1;
            HDR_TC1: phase = HDR_FLAGS;
            HDR_FLAGS: begin
                lace_desc_t d;
                mode = i_byte_value[2:1];
                if (mode == MODE_NONE) begin
                    phase = HDR_IDLE;
                    d.size = rem[SizeW-1:0];
                    d.ltime = hold_valid ? base[TimeW-1:0] : '0;
                    d.tv = hold_valid;
                    d.num = '0;
                    d.last = 1'b1;
                    d.err = ERR_NONE;
                    exp_laces.push_back(d);
                end else begin
                    phase = HDR_COUNT;
                end
            end
            HDR_COUNT: begin
                if (b + 1 > MAX_LACES) push_error(ERR_COUNT);
                else if (rem == 0) push_error(ERR_SIZE);
                else begin
                    rem--;
                    count = b + 1;
                    cursor = 0; run_acc = 0; sum_sizes = 0;
                    if (mode == MODE_FIXED || count == 1) emit_laces();
                    else phase = (mode == MODE_XIPH) ? HDR_XIPH : HDR_VHEAD;
                end
            end
            HDR_XIPH: begin
                if (rem < b + 1) push_error(ERR_SIZE);
                else begin
                    rem -= b + 1;
                    run_acc += b;
                    if (i_byte_value != XIPH_RUN) begin
                        sizes[cursor % 64] = run_acc;
                        sum_sizes += run_acc;
                        run_acc = 0;
                        cursor++;
                        if (cursor + 1 >= count) emit_laces();
                    end
                end
            end
            HDR_VHEAD: begin
                if (rem == 0) push_error(ERR_SIZE);
                else begin
                    rem--;
                    if (b == 0) push_error(ERR_SIZE);
                    else begin
                        mask = 8'h80;
                        len = 1;
                        while ((i_byte_value & mask) == 0) begin
                            mask >>= 1;
                            len++;
                        end
                        vval = 56'(i_byte_value & (mask - 8'd1));
                        vlen = len;
                        vleft = len - 1;
                        if (vleft == 0) close_vint();
                        else phase = HDR_VREST;
                    end
                end
            end
            HDR_VREST: begin
                if (rem == 0) push_error(ERR_SIZE);
                else begin
                    rem--;
                    vval = {vval[47:0], i_byte_value};
                    if (vleft > 0) vleft--;
                    if (vleft == 0) close_vint();
                end
            end
            default: phase = HDR_IDLE;
        endcase
    endtask

    task automatic check_beat();
        lace_desc_t e;
        lace_desc_t a;
        a = {i_lace_size, i_lace_time, i_time_valid, i_lace_number, i_last_lace,
             i_error_code};
        if (exp_laces.size() == 0) begin
            $display("%t unexpected descriptor beat %p", $time, a);
            o_fail_count++;
            return;
        end
        e = exp_laces.pop_front();
        if (e.size !== a.size) begin
            $display("%t lace_size exp %0d got %0d", $time, e.size, a.size);
            o_fail_count++;
        end
        if (e.ltime !== a.ltime) begin
            $display("%t lace_time exp %0d got %0d", $time, e.ltime, a.ltime);
            o_fail_count++;
        end
        if (e.tv !== a.tv) begin
            $display("%t time_valid exp %0d got %0d", $time, e.tv, a.tv);
            o_fail_count++;
        end
        if (e.num !== a.num) begin
            $display("%t lace_number exp %0d got %0d", $time, e.num, a.num);
            o_fail_count++;
        end
        if (e.last !== a.last) begin
            $display("%t last_lace exp %0d got %0d", $time, e.last, a.last);
            o_fail_count++;
        end
        if (e.err !== a.err) begin
            $display("%t error_code exp %0d got %0d", $time, e.err, a.err);
            o_fail_count++;
        end
    endtask

    initial begin
        o_fail_count = 0;
        o_pending = 0;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            phase = HDR_IDLE;
            mode = MODE_NONE;
            count = 0; cursor = 0; run_acc = 0; vleft = 0; vlen = 0;
            rem = 0; sum_sizes = 0; vval = '0;
            step = '0; base = '0; nxt = '0;
            hold_next = 1'b0; hold_valid = 1'b0;
            exp_laces.delete();
        end else begin
            if (i_in_valid && !i_in_stall) take_beat();
            if (i_out_valid && !i_out_stall) check_beat();
        end
        o_pending <= exp_laces.size();
    end
endmodule

[tb/sv/matroska_lace_header_parser_top_tb.sv]
// ---------------------------------------------------------------------------
// matroska_lace_header_parser_top_tb
// stimulus and verdict for the lace header parser
// ---------------------------------------------------------------------------
// directed blocks cover each lacing mode, the error paths, stray bytes and a
// restart; then random blocks, mostly well formed, some broken, some noise,
// under three idling profiles; a separate checker predicts and compares
// ---------------------------------------------------------------------------
module matroska_lace_header_parser_top_tb;
    import mlhp_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned WATCHDOG_LIMIT = 5000;

    logic             i_clk;
    logic             i_rst_n;
    logic             i_in_valid;
    logic             o_in_stall;
    logic             i_command;
    logic [7:0]       i_byte_value;
    logic [SizeW-1:0] i_block_size;
    logic [TimeW-1:0] i_block_time;
    logic [TimeW-1:0] i_next_time;
    logic             i_has_next;
    logic             i_is_first_block;
    logic             o_out_valid;
    logic             i_out_stall;
    logic [SizeW-1:0] o_lace_size;
    logic [TimeW-1:0] o_lace_time;
    logic             o_time_valid;
    logic [IdxW-1:0]  o_lace_number;
    logic             o_last_lace;
    logic [1:0]       o_error_code;

    int               fail_count;
    int               pending;
    int               beats_sent;
    int               gap_pct;
    int               stall_pct;
    int               idle_cycles;

    matroska_lace_header_parser_top DUT (.*);

    lace_descriptor_checker u_checker (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .i_in_stall       (o_in_stall),
        .i_command        (i_command),
        .i_byte_value     (i_byte_value),
        .i_block_size     (i_block_size),
        .i_block_time     (i_block_time),
        .i_next_time      (i_next_time),
        .i_has_next       (i_has_next),
        .i_is_first_block (i_is_first_block),
        .i_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .i_lace_size      (o_lace_size),
        .i_lace_time      (o_lace_time),
        .i_time_valid     (o_time_valid),
        .i_lace_number    (o_lace_number),
        .i_last_lace      (o_last_lace),
        .i_error_code     (o_error_code),
        .o_fail_count     (fail_count),
        .o_pending        (pending)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // receiver stall, redrawn every falling edge from the current profile
    always @(negedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < stall_pct);
    end

    // watchdog: any stretch with no beat on either side is bounded
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    function automatic logic [TimeW-1:0] rand_time();
        case ($urandom_range(3))
            0: return '0;
            1: return TimeW'($urandom_range(100000));
            default: return TimeW'({$urandom, $urandom});
        endcase
    endfunction

    // one input beat; called and returns at a falling edge
    task automatic send_beat(input logic cmd, input logic [7:0] b,
                             input logic [SizeW-1:0] bs, input logic [TimeW-1:0] bt,
                             input logic [TimeW-1:0] nt, input logic hn,
                             input logic fb);
        logic stalled;
        if ($urandom_range(99) < gap_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
            while ($urandom_range(99) < gap_pct) @(negedge i_clk);
        end
        i_in_valid       <= 1'b1;
        i_command        <= cmd;
        i_byte_value     <= b;
        i_block_size     <= bs;
        i_block_time     <= bt;
        i_next_time      <= nt;
        i_has_next       <= hn;
        i_is_first_block <= fb;
        // sample stall just ahead of the rising edge, once inputs have settled
        forever begin
            #4;
            stalled = o_in_stall;
            @(negedge i_clk);
            if (!stalled) break;
        end
        beats_sent++;
    endtask

    // header byte beat, unused fields random
    task automatic send_byte(input logic [7:0] b);
        send_beat(1'b1, b, SizeW'($urandom), rand_time(), rand_time(), 1'($urandom),
                  1'($urandom));
    endtask

    task automatic push_vint(ref logic [7:0] hdr[$], input longint unsigned v,
                             input int len);
        longint unsigned full;
        full = (longint'(1) << (7 * len)) | v;
        for (int k = 0; k < len; k++) hdr.push_back(8'(full >> (8 * (len - 1 - k))));
    endtask

    // a whole block: start beat then header bytes; broken blocks get one fault
    task automatic send_block(input logic [1:0] mode, input int n, input bit healthy,
                              input bit wide, input logic [TimeW-1:0] bt,
                              input logic [TimeW-1:0] nt, input logic hn,
                              input logic fb);
        logic [7:0]      hdr[$];
        int unsigned     lens[$];
        int unsigned     total, each, cut;
        logic [SizeW-1:0] bs;
        longint          d, bias;
        int              len;
        hdr.push_back(8'($urandom));
        hdr.push_back(8'($urandom));
        hdr.push_back((8'($urandom) & 8'hf9) | {5'd0, mode, 1'b0});
        total = 0;
        if (mode == MODE_NONE) begin
            total = wide ? $urandom_range(16000) : $urandom_range(40);
        end else begin
            hdr.push_back(8'(n - 1));
            if (n <= 64) begin
                for (int i = 0; i < n; i++) begin
                    lens.push_back(wide ? $urandom_range(3000) : $urandom_range(40));
                    if (mode == MODE_EBML && i > 0 && lens[i] == 0) lens[i] = 1;
                end
                if (mode == MODE_FIXED) begin
                    each = lens[0];
                    total = n * each + $urandom_range(n - 1);
                end else begin
                    foreach (lens[i]) total += lens[i];
                end
                for (int i = 0; i < n - 1 && mode == MODE_XIPH; i++) begin
                    each = lens[i];
                    while (each >= 255) begin
                        hdr.push_back(XIPH_RUN);
                        each -= 255;
                    end
                    hdr.push_back(8'(each));
                end
                for (int i = 0; i < n - 1 && mode == MODE_EBML; i++) begin
                    if (i == 0) begin
                        len = 1;
                        while (longint'(lens[0]) >= (longint'(1) << (7 * len))) len++;
                        if (len < 8 && $urandom_range(3) == 0) len++;
                        push_vint(hdr, lens[0], len);
                    end else begin
                        d = longint'(lens[i]) - longint'(lens[i - 1]);
                        len = 1;
                        forever begin
                            bias = (longint'(1) << (7 * len - 1)) - 1;
                            if (d + bias >= 0 && d + bias < (longint'(1) << (7 * len))) break;
                            len++;
                        end
                        push_vint(hdr, d + bias, len);
                    end
                end
            end
        end
        bs = SizeW'(hdr.size() + total);
        if (!healthy) begin
            case ($urandom_range(3))
                0: bs = SizeW'($urandom);
                1: bs = SizeW'($urandom_range(hdr.size()));
                2: hdr[$urandom_range(hdr.size() - 1)] = 8'($urandom);
                default: begin
                    cut = $urandom_range(hdr.size() - 1);
                    while (hdr.size() > cut) void'(hdr.pop_back());
                end
            endcase
        end
        send_beat(1'b0, 8'($urandom), bs, bt, nt, hn, fb);
        foreach (hdr[i]) send_byte(hdr[i]);
    endtask

    // sender goes quiet until every predicted descriptor has come back
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
    endtask

    initial begin
        int unsigned pick;
        logic [TimeW-1:0] bt;
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_command = 1'b0;
        i_byte_value = '0;
        i_block_size = '0;
        i_block_time = '0;
        i_next_time = '0;
        i_has_next = 1'b0;
        i_is_first_block = 1'b0;
        i_out_stall = 1'b0;
        gap_pct = 12;
        stall_pct = 53;
        beats_sent = 0;
        idle_cycles = 0;
        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: stray byte while idle, short block with maximal time
        send_byte(8'hff);
        send_beat(1'b0, 8'h00, '0, '1, '0, 1'b0, 1'b1);
        send_byte(8'h00); send_byte(8'hff); send_byte(8'h00);
        // widest block size with time missing on a later block
        send_beat(1'b0, 8'hff, '1, '0, '1, 1'b1, 1'b0);
        send_byte(8'hff); send_byte(8'h00); send_byte(8'hf9);
        // fixed lacing at the lace limit, next block earlier than this one
        send_block(MODE_FIXED, 64, 1, 1, 63'd5000, 63'd100, 1'b1, 1'b0);
        send_block(MODE_XIPH, 4, 1, 1, 63'd1000, 63'd9000, 1'b1, 1'b0);
        send_block(MODE_EBML, 5, 1, 1, 63'd2000, 63'd2999, 1'b1, 1'b1);
        // one lace too many
        send_block(MODE_XIPH, 65, 1, 0, 63'd7, 63'd9, 1'b1, 1'b0);
        // zero first vint byte
        send_beat(1'b0, 8'h00, 24'd100, 63'd50, 63'd80, 1'b1, 1'b0);
        send_byte(8'h00); send_byte(8'h00); send_byte(8'h06);
        send_byte(8'h02); send_byte(8'h00);
        // header runs past the block: no room for the count byte
        send_beat(1'b0, 8'h00, 24'd3, 63'd50, 63'd80, 1'b0, 1'b0);
        send_byte(8'h00); send_byte(8'h00); send_byte(8'h02); send_byte(8'h01);
        // restart part way through a header
        send_beat(1'b0, 8'h00, 24'd40, 63'd1, 63'd2, 1'b1, 1'b0);
        send_byte(8'h00);
        send_block(MODE_EBML, 3, 1, 0, 63'd300, 63'd600, 1'b1, 1'b0);
        wait_drained();

        // random part under three idling profiles
        while (beats_sent < 350) begin
            if (beats_sent > 120 && beats_sent <= 240) begin
                gap_pct = 53;
                stall_pct = 12;
            end else if (beats_sent > 240) begin
                gap_pct = 0;
                stall_pct = 0;
            end
            // sender holds off until every descriptor is back
            if (beats_sent > 160 && beats_sent < 180) wait_drained();
            pick = $urandom_range(99);
            bt = rand_time();
            if (pick < 8) begin
                send_byte(8'($urandom));
            end else begin
                send_block(2'($urandom), ($urandom_range(15) == 0) ? 64 :
                           ($urandom_range(19) == 0) ? $urandom_range(65, 256) :
                           $urandom_range(1, 8),
                           pick >= 25, $urandom_range(4) == 0, bt,
                           ($urandom_range(1) == 0) ? bt + TimeW'($urandom_range(5000)) :
                           rand_time(), 1'($urandom), ($urandom_range(7) == 0));
            end
        end

        wait_drained();
        repeat (400) @(negedge i_clk);
        if (fail_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end
endmodule

[files.f]
rtl/mlhp_pkg.sv
rtl/mlhp_div.sv
rtl/mlhp_front.sv
rtl/mlhp_back.sv
rtl/matroska_lace_header_parser_top.sv
tb/sv/lace_descriptor_checker.sv
tb/sv/matroska_lace_header_parser_top_tb.sv
